>>> rtl/ffrr_pkg.sv
// Shared constants and types for the fixed-length frame receiver.
// No dependencies; imported by every module of the block.
package ffrr_pkg;

    localparam int FRAME_BYTES = 16;
    localparam int BYTE_W      = 8;
    localparam int POS_W       = 4;
    localparam int FILL_W      = $clog2(FRAME_BYTES + 1);
    localparam int CFG_IDX_W   = 1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_HEADER = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_FOOTER = 1'b1;

    localparam logic [BYTE_W-1:0] HEADER_RESET = 8'd170;
    localparam logic [BYTE_W-1:0] FOOTER_RESET = 8'd85;

    // control handed to every frame cell
    typedef struct packed {
        logic              shift;
        logic [BYTE_W-1:0] header;
    } t_cell_ctl;

endpackage

>>> rtl/ffrr_cell.sv
// One frame cell: holds one byte of the frame line and checks the byte
// entering it against the header for resync. Depends on ffrr_pkg.
module ffrr_cell
    import ffrr_pkg::*;
(
    input  logic              i_clk,
    input  t_cell_ctl         i_ctl,
    input  logic [BYTE_W-1:0] i_byte,
    input  logic              i_hit,
    output logic [BYTE_W-1:0] o_byte,
    output logic              o_hit,
    output logic              o_first
);

    logic [BYTE_W-1:0] r_byte;
    logic              w_match;

    // compare the incoming byte: it is this cell's content after the shift
    assign w_match = (i_byte == i_ctl.header);
    assign o_hit   = i_hit | w_match;
    assign o_first = w_match & ~i_hit;
    assign o_byte  = r_byte;

    always_ff @(posedge i_clk) begin
        if (i_ctl.shift) begin
            r_byte <= i_byte;
        end
    end

endmodule

>>> rtl/ffrr_drain_cell.sv
// One output cell: loaded in parallel with a good frame, then shifts one
// position toward the output per delivered byte. Depends on ffrr_pkg.
module ffrr_drain_cell
    import ffrr_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_load,
    input  logic              i_shift,
    input  logic [BYTE_W-1:0] i_load_byte,
    input  logic [BYTE_W-1:0] i_byte,
    output logic [BYTE_W-1:0] o_byte
);

    logic [BYTE_W-1:0] r_byte;

    assign o_byte = r_byte;

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_byte <= i_load_byte;
        end else if (i_shift) begin
            r_byte <= i_byte;
        end
    end

endmodule

>>> rtl/fixed_frame_receiver_resync_core.sv
// Top level of the fixed-length frame receiver with header/footer resync.
// Depends on ffrr_pkg, ffrr_cell and ffrr_drain_cell.
//
//   channel | valid        | stall        | payload
//   --------+--------------+--------------+------------------------------------
//   rx      | i_rx_valid   | o_rx_stall   | i_rx_byte
//   out     | o_out_valid  | i_out_stall  | o_frame_byte, o_byte_position,
//           |              |              | o_last_of_frame
//   cfg     | i_cfg_wr_en  | -            | i_cfg_index, i_cfg_data
//
// An accepted received byte shifts into the frame cell line. A good frame
// is copied into the output cell line as its footer byte is accepted and
// drains one byte per cycle when i_out_stall is low, as the
// next frame keeps filling. rx stalls only when a byte would complete a
// frame while the previous frame is still draining.
// Reset (synchronous, active low) returns to hunting with an empty output.
module fixed_frame_receiver_resync_core
    import ffrr_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [BYTE_W-1:0]    i_cfg_data,
    input  logic                 i_rx_valid,
    output logic                 o_rx_stall,
    input  logic [BYTE_W-1:0]    i_rx_byte,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [BYTE_W-1:0]    o_frame_byte,
    output logic [POS_W-1:0]     o_byte_position,
    output logic                 o_last_of_frame
);

    logic [BYTE_W-1:0] r_header;
    logic [BYTE_W-1:0] r_footer;
    logic [FILL_W-1:0] r_fill;
    logic [FILL_W-1:0] n_fill;
    logic [FILL_W-1:0] r_left;
    logic [FILL_W-1:0] n_left;

    logic              w_in_acc;
    logic              w_out_acc;
    logic              w_full_next;
    logic              w_load;
    logic [FILL_W-1:0] w_resync_fill;
    logic [FILL_W-1:0] w_pos;
    t_cell_ctl         w_ctl;

    logic [BYTE_W-1:0] w_cell_byte  [FRAME_BYTES];
    logic [BYTE_W-1:0] w_cell_in    [FRAME_BYTES];
    logic              w_hit_in     [FRAME_BYTES];
    logic              w_hit_out    [FRAME_BYTES];
    logic              w_first      [FRAME_BYTES];
    logic [BYTE_W-1:0] w_drain_byte [FRAME_BYTES];
    logic [BYTE_W-1:0] w_drain_in   [FRAME_BYTES];

    assign w_full_next = (r_fill == FILL_W'(FRAME_BYTES - 1));
    assign o_rx_stall  = (r_left != '0) && w_full_next;
    assign w_in_acc    = i_rx_valid && !o_rx_stall;
    assign o_out_valid = (r_left != '0);
    assign w_out_acc   = o_out_valid && !i_out_stall;
    assign w_load      = w_in_acc && (r_fill != '0) && w_full_next
                         && (i_rx_byte == r_footer);

    assign w_ctl.shift  = w_in_acc;
    assign w_ctl.header = r_header;

    // frame line: newest byte enters at the top, frame position i sits in
    // cell i once the frame is complete
    genvar gi;
    generate
        for (gi = 0; gi < FRAME_BYTES; gi++) begin : g_cell
            if (gi == FRAME_BYTES - 1) begin : g_top
                assign w_cell_in[gi]  = i_rx_byte;
                assign w_drain_in[gi] = '0;
            end else begin : g_mid
                assign w_cell_in[gi]  = w_cell_byte[gi+1];
                assign w_drain_in[gi] = w_drain_byte[gi+1];
            end

            // cell 0 never takes part in the resync search
            if (gi == 0) begin : g_hit0
                assign w_hit_in[gi] = 1'b1;
            end else if (gi == 1) begin : g_hit1
                assign w_hit_in[gi] = 1'b0;
            end else begin : g_hitn
                assign w_hit_in[gi] = w_hit_out[gi-1];
            end

            ffrr_cell u_cell (
                .i_clk   (i_clk),
                .i_ctl   (w_ctl),
                .i_byte  (w_cell_in[gi]),
                .i_hit   (w_hit_in[gi]),
                .o_byte  (w_cell_byte[gi]),
                .o_hit   (w_hit_out[gi]),
                .o_first (w_first[gi])
            );

            ffrr_drain_cell u_drain (
                .i_clk       (i_clk),
                .i_load      (w_load),
                .i_shift     (w_out_acc),
                .i_load_byte (w_cell_in[gi]),
                .i_byte      (w_drain_in[gi]),
                .o_byte      (w_drain_byte[gi])
            );
        end
    endgenerate

    // keep the tail starting at the first header match
    always_comb begin
        w_resync_fill = '0;
        for (int i = 1; i < FRAME_BYTES; i++) begin
            if (w_first[i]) begin
                w_resync_fill = w_resync_fill | FILL_W'(FRAME_BYTES - i);
            end
        end
    end

    always_comb begin
        n_fill = r_fill;
        if (w_in_acc) begin
            if (r_fill == '0) begin
                n_fill = (i_rx_byte == r_header) ? FILL_W'(1) : '0;
            end else if (w_full_next) begin
                n_fill = (i_rx_byte == r_footer) ? '0 : w_resync_fill;
            end else begin
                n_fill = r_fill + FILL_W'(1);
            end
        end
    end

    always_comb begin
        n_left = r_left;
        if (w_load) begin
            n_left = FILL_W'(FRAME_BYTES);
        end else if (w_out_acc) begin
            n_left = r_left - FILL_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_header <= HEADER_RESET;
            r_footer <= FOOTER_RESET;
            r_fill   <= '0;
            r_left   <= '0;
        end else begin
            r_fill <= n_fill;
            r_left <= n_left;
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    REG_HEADER: r_header <= i_cfg_data;
                    REG_FOOTER: r_footer <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    assign w_pos           = FILL_W'(FRAME_BYTES) - r_left;
    assign o_frame_byte    = w_drain_byte[0];
    assign o_byte_position = POS_W'(w_pos);
    assign o_last_of_frame = (r_left == FILL_W'(1));

endmodule

>>> tb/sv/fixed_frame_receiver_resync_core_tb.sv
// Self-checking testbench for fixed_frame_receiver_resync_core.
// Depends on ffrr_pkg and the RTL of the block; a frame predictor in the bench
// builds the expected byte runs, which are checked against every output request.
`timescale 1ns / 1ps

module fixed_frame_receiver_resync_core_tb
    import ffrr_pkg::*;
();

    localparam int CYCLE_LIMIT = 200000;
    localparam int SETTLE_CYCLES = 8;

    typedef struct {
        logic [BYTE_W-1:0] data_b;
        logic [POS_W-1:0]  pos;
        logic              last;
    } t_frame_beat;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [BYTE_W-1:0]    cfg_data = '0;
    logic                 rx_valid = 1'b0;
    logic [BYTE_W-1:0]    rx_byte = '0;
    logic                 out_stall = 1'b0;
    logic                 rx_stall;
    logic                 out_valid;
    logic [BYTE_W-1:0]    frame_byte;
    logic [POS_W-1:0]     byte_position;
    logic                 last_of_frame;

    // frame predictor state
    logic [BYTE_W-1:0] held_bytes [FRAME_BYTES];
    int                held_count = 0;
    logic [BYTE_W-1:0] hdr_reg = HEADER_RESET;
    logic [BYTE_W-1:0] ftr_reg = FOOTER_RESET;
    t_frame_beat       expected_beats [$];

    bit idle_on = 1'b1;
    int mismatch_count = 0;
    int cycle_count = 0;
    int bytes_sent = 0;
    int beats_checked = 0;
    int frames_seen = 0;
    int settings_used = 0;

    fixed_frame_receiver_resync_core dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (cfg_wr_en),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data),
        .i_rx_valid     (rx_valid),
        .o_rx_stall     (rx_stall),
        .i_rx_byte      (rx_byte),
        .o_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .o_frame_byte   (frame_byte),
        .o_byte_position(byte_position),
        .o_last_of_frame(last_of_frame)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d beats still expected",
                     cycle_count, expected_beats.size());
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic note_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= 10) $display("mismatch: %s", msg);
    endtask

    // Advance the frame predictor by one accepted byte.
    task automatic predict_frame(input logic [BYTE_W-1:0] b);
        t_frame_beat beat;
        int          k;
        int          shift_at;
        if (held_count == 0) begin
            if (b == hdr_reg) begin
                held_bytes[0] = b;
                held_count = 1;
            end
        end else begin
            held_bytes[held_count] = b;
            held_count++;
            if (held_count == FRAME_BYTES) begin
                if (b == ftr_reg) begin
                    for (k = 0; k < FRAME_BYTES; k++) begin
                        beat.data_b = held_bytes[k];
                        beat.pos = k[POS_W-1:0];
                        beat.last = (k == FRAME_BYTES - 1);
                        expected_beats.push_back(beat);
                    end
                    frames_seen++;
                    held_count = 0;
                end else begin
                    // resync on the first later header byte, else drop the frame
                    shift_at = 0;
                    for (k = 1; k < FRAME_BYTES && shift_at == 0; k++)
                        if (held_bytes[k] == hdr_reg) shift_at = k;
                    held_count = 0;
                    if (shift_at != 0) begin
                        for (k = shift_at; k < FRAME_BYTES; k++)
                            held_bytes[k - shift_at] = held_bytes[k];
                        held_count = FRAME_BYTES - shift_at;
                    end
                end
            end
        end
    endtask

    always @(posedge i_clk) begin
        t_frame_beat want;
        if (i_rst_n && out_valid && !out_stall) begin
            beats_checked++;
            if (expected_beats.size() == 0) begin
                note_mismatch($sformatf("unexpected beat byte=%02h pos=%0d last=%0b",
                                        frame_byte, byte_position, last_of_frame));
            end else begin
                want = expected_beats.pop_front();
                if (frame_byte !== want.data_b || byte_position !== want.pos ||
                    last_of_frame !== want.last)
                    note_mismatch($sformatf(
                        "expected byte=%02h pos=%0d last=%0b, got byte=%02h pos=%0d last=%0b",
                        want.data_b, want.pos, want.last,
                        frame_byte, byte_position, last_of_frame));
            end
        end
    end

    // Output stall in random bursts while idling is on.
    always @(negedge i_clk) begin
        static int burst_left = 0;
        logic next_stall;
        next_stall = 1'b0;
        if (idle_on) begin
            if (burst_left > 0) begin
                burst_left--;
                next_stall = 1'b1;
            end else if ($urandom_range(0, 3) == 0) begin
                burst_left = $urandom_range(0, 8);
                next_stall = 1'b1;
            end
        end
        out_stall <= next_stall;
    end

    // Send one rx request; valid stays high until the next call or a drain.
    task automatic send_rx(input logic [BYTE_W-1:0] b);
        int gap;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 9);
            @(negedge i_clk);
            rx_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        rx_valid <= 1'b1;
        rx_byte <= b;
        do @(posedge i_clk); while (rx_stall);
        bytes_sent++;
        predict_frame(b);
    endtask

    // Hold off rx until every expected beat is out, then let the core settle.
    task automatic wait_drain();
        @(negedge i_clk);
        rx_valid <= 1'b0;
        while (expected_beats.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [BYTE_W-1:0] val);
        wait_drain();
        @(negedge i_clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge i_clk);
        if (idx == REG_HEADER) hdr_reg = val;
        else ftr_reg = val;
        @(negedge i_clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic set_markers(input logic [BYTE_W-1:0] hdr, input logic [BYTE_W-1:0] ftr);
        write_reg(REG_HEADER, hdr);
        write_reg(REG_FOOTER, ftr);
        settings_used++;
    endtask

    // Header, fill bytes, then the given final byte.
    task automatic send_frame(input logic [BYTE_W-1:0] fill, input logic [BYTE_W-1:0] tail);
        int i;
        send_rx(hdr_reg);
        for (i = 1; i < FRAME_BYTES - 1; i++) send_rx(fill ^ i[BYTE_W-1:0]);
        send_rx(tail);
    endtask

    task automatic send_random_frame(input bit good);
        logic [BYTE_W-1:0] b;
        int i;
        for (i = 0; i < FRAME_BYTES; i++) begin
            if (i == 0) begin
                b = hdr_reg;
            end else if (i == FRAME_BYTES - 1) begin
                b = ftr_reg;
                if (!good) begin
                    do b = BYTE_W'($urandom_range(0, 255)); while (b == ftr_reg);
                end
            end else if ($urandom_range(0, 11) == 0) begin
                b = hdr_reg;
            end else begin
                b = BYTE_W'($urandom_range(0, 255));
            end
            send_rx(b);
        end
    endtask

    task automatic test_reset_markers();
        // noise while hunting, then a good frame with the reset markers
        send_rx(8'h00);
        send_rx(8'hFF);
        send_frame(8'h00, FOOTER_RESET);
        wait_drain();
    endtask

    task automatic test_extreme_markers();
        set_markers(8'h00, 8'hFF);
        send_frame(8'hF0, 8'hFF);
        set_markers(8'hFF, 8'h00);
        send_frame(8'h0F, 8'h00);
        wait_drain();
    endtask

    task automatic test_drop_and_resync();
        int i;
        set_markers(8'hAA, 8'h55);
        // bad footer, no later header: drop
        send_frame(8'h10, 8'h66);
        // bad footer with a header at position 5: keep 11 bytes, add 5
        send_rx(8'hAA);
        for (i = 1; i < FRAME_BYTES - 1; i++) send_rx(i == 5 ? 8'hAA : BYTE_W'(8'h20 + i));
        send_rx(8'h77);
        for (i = 0; i < 4; i++) send_rx(BYTE_W'(8'h30 + i));
        send_rx(8'h55);
        wait_drain();
    endtask

    task automatic test_single_byte_resync();
        int i;
        // only the final byte matches the header: one byte survives
        send_frame(8'h40, 8'hAA);
        for (i = 1; i < FRAME_BYTES - 1; i++) send_rx(BYTE_W'(8'h50 + i));
        send_rx(8'h55);
        wait_drain();
    endtask

    task automatic test_header_equals_footer();
        set_markers(8'h3C, 8'h3C);
        send_frame(8'h80, 8'h3C);
        wait_drain();
    endtask

    task automatic test_mid_frame_change();
        int i;
        set_markers(8'hAA, 8'h55);
        send_rx(8'hAA);
        for (i = 1; i < 6; i++) send_rx(BYTE_W'(8'h60 + i));
        write_reg(REG_FOOTER, 8'hC3);
        for (i = 6; i < FRAME_BYTES - 1; i++) send_rx(i == 9 ? 8'h5A : BYTE_W'(8'h60 + i));
        // the header moves to 0x5A before the footer check: resync lands on 0x5A
        write_reg(REG_HEADER, 8'h5A);
        send_rx(8'h01);
        for (i = 0; i < 8; i++) send_rx(BYTE_W'(8'h70 + i));
        send_rx(8'hC3);
        wait_drain();
    endtask

    task automatic test_random_traffic();
        logic [BYTE_W-1:0] hdr_set [5] = '{8'hAA, 8'h00, 8'hFF, 8'h3C, 8'h5A};
        logic [BYTE_W-1:0] ftr_set [5] = '{8'h55, 8'hFF, 8'h00, 8'h3C, 8'hA5};
        int phase;
        int phase_start;
        int pick;
        int i;
        for (phase = 0; phase < 7; phase++) begin
            if (phase < 5) set_markers(hdr_set[phase], ftr_set[phase]);
            else set_markers(BYTE_W'($urandom_range(0, 255)), BYTE_W'($urandom_range(0, 255)));
            // the last phase runs with no idling on either side
            if (phase == 6) begin
                wait_drain();
                idle_on = 1'b0;
            end
            phase_start = bytes_sent;
            while (bytes_sent - phase_start < 20) begin
                pick = $urandom_range(0, 9);
                if (pick < 6) begin
                    send_random_frame(1'b1);
                end else if (pick < 8) begin
                    send_random_frame(1'b0);
                end else if (pick == 8) begin
                    for (i = $urandom_range(1, 6); i > 0; i--)
                        send_rx(BYTE_W'($urandom_range(0, 255)));
                end else begin
                    wait_drain();
                end
            end
        end
        wait_drain();
    endtask

    initial begin
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_reset_markers();
        test_extreme_markers();
        test_drop_and_resync();
        test_single_byte_resync();
        test_header_equals_footer();
        test_mid_frame_change();
        test_random_traffic();

        repeat (20) @(posedge i_clk);
        if (expected_beats.size() != 0)
            note_mismatch($sformatf("%0d beats never came out", expected_beats.size()));

        $display("covered %0d rx bytes over %0d marker settings", bytes_sent, settings_used);
        $display("checked %0d output beats from %0d good frames, %0d mismatches",
                 beats_checked, frames_seen, mismatch_count);
        if (mismatch_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
